[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define CMEF_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cmef: same-cycle property violated");

// Next-cycle implication, muted while reset is asserted.
`define CMEF_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cmef: next-cycle property violated");

`endif

[rtl/core/cmef_pkg.sv]
package cmef_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned WSIZE_W    = 3;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned FRAC_BITS  = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA   = 2'd3;

  localparam logic [LIMIT_W-1:0] MIN_LIMIT_RST   = 16'h8000;
  localparam logic [LIMIT_W-1:0] MAX_LIMIT_RST   = 16'h7FFF;
  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 3'd5;
  localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST   = 16'd8192;

  // Q1.15 unity weight
  localparam logic [ALPHA_W:0] ALPHA_ONE = 17'd32768;

  typedef struct packed {
    logic capture;
    logic load;
    logic prep;
    logic sort;
    logic med;
    logic diff;
    logic mul;
    logic upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sort_last;
  } sts_t;

endpackage

[rtl/core/cmef_ctrl.sv]
module cmef_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cmef_pkg::cmd_t  cmd_o,
  input  cmef_pkg::sts_t  sts_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_SORT = 4'd3;
  localparam logic [3:0] S_MED  = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_SORT;
      end
      S_SORT: begin
        cmd_o.sort = 1'b1;
        if (sts_i.sort_last) begin
          state_d = S_MED;
        end
      end
      S_MED: begin
        cmd_o.med = 1'b1;
        state_d   = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/cmef_datapath.sv]
module cmef_datapath #(
  parameter int MAX_WINDOW  = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cmef_pkg::cmd_t                         cmd_i,
  output cmef_pkg::sts_t                         sts_o,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  input  logic                                   cfg_we_i,
  input  logic [cmef_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [cmef_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic signed [SAMPLE_BITS-1:0]          clamped_o,
  output logic signed [SAMPLE_BITS-1:0]          median_o,
  output logic signed [SAMPLE_BITS-1:0]          filtered_o,
  output logic                                   ready_res_o
);

  // internal sample width covers both the port and the 16-bit limits
  localparam int CW  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int PW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int NW  = $clog2(MAX_WINDOW + 1);
  localparam int DW  = CW + 1;
  localparam int PRW = DW + cmef_pkg::ALPHA_W + 2;

  // configuration
  logic signed [cmef_pkg::LIMIT_W-1:0] min_q, max_q;
  logic [cmef_pkg::WSIZE_W-1:0]        ws_q;
  logic [cmef_pkg::ALPHA_W-1:0]        alpha_q;

  // window state
  logic signed [CW-1:0] win_q [MAX_WINDOW];
  logic [PW-1:0]        ptr_q;
  logic [NW-1:0]        count_q;
  logic signed [CW-1:0] avg_q;
  logic                 seeded_q;

  // working registers
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [CW-1:0]          clamp_q;
  logic signed [CW-1:0]          val_q [MAX_WINDOW];
  logic                          pad_q [MAX_WINDOW];
  logic [NW-1:0]                 round_q;
  logic [PW-1:0]                 med_idx_q;
  logic                          ready_q;
  logic signed [CW-1:0]          med_q;
  logic signed [DW-1:0]          diff_q;
  logic signed [PRW-1:0]         prod_q;

  // result register
  logic signed [SAMPLE_BITS-1:0] clamped_q, median_q, filtered_q;
  logic                          ready_res_q;

  logic [NW-1:0]                 size;
  logic [NW-1:0]                 n_used;
  logic [PW-1:0]                 ptr_eff, ptr_nxt;
  logic signed [CW-1:0]          x_ext, lo_ext, hi_ext, clamp_val;
  logic [cmef_pkg::ALPHA_W:0]    alpha_eff;
  logic signed [CW-1:0]          val_n [MAX_WINDOW];
  logic                          pad_n [MAX_WINDOW];
  logic signed [PRW-1:0]         avg_sum;

  always_comb begin
    if (ws_q == '0) begin
      size = NW'(1);
    end else if (int'(ws_q) > MAX_WINDOW) begin
      size = NW'(MAX_WINDOW);
    end else begin
      size = NW'(ws_q);
    end
  end

  assign n_used = (count_q < size) ? count_q : size;

  // restart the pointer when the window shrank below it
  assign ptr_eff = (NW'(ptr_q) >= size) ? '0 : ptr_q;
  assign ptr_nxt = ((NW'(ptr_eff) + NW'(1)) == size) ? '0 : PW'(NW'(ptr_eff) + NW'(1));

  assign x_ext  = CW'(sample_q);
  assign lo_ext = CW'(min_q);
  assign hi_ext = CW'(max_q);

  always_comb begin
    if (x_ext < lo_ext) begin
      clamp_val = lo_ext;
    end else if (x_ext > hi_ext) begin
      clamp_val = hi_ext;
    end else begin
      clamp_val = x_ext;
    end
  end

  assign alpha_eff = ({1'b0, alpha_q} > cmef_pkg::ALPHA_ONE) ? cmef_pkg::ALPHA_ONE
                                                            : {1'b0, alpha_q};

  // one odd-even transposition round; padding lanes sort above every sample
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      val_n[i] = val_q[i];
      pad_n[i] = pad_q[i];
    end
    for (int i = 0; i < MAX_WINDOW - 1; i++) begin
      if ((i[0] == round_q[0]) &&
          ((pad_q[i] && !pad_q[i+1]) ||
           (!pad_q[i] && !pad_q[i+1] && (val_q[i] > val_q[i+1])))) begin
        val_n[i]   = val_q[i+1];
        val_n[i+1] = val_q[i];
        pad_n[i]   = pad_q[i+1];
        pad_n[i+1] = pad_q[i];
      end
    end
  end

  assign avg_sum = (prod_q >>> cmef_pkg::FRAC_BITS) + PRW'(avg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= cmef_pkg::MIN_LIMIT_RST;
      max_q    <= cmef_pkg::MAX_LIMIT_RST;
      ws_q     <= cmef_pkg::WINDOW_SIZE_RST;
      alpha_q  <= cmef_pkg::EMA_ALPHA_RST;
      ptr_q    <= '0;
      count_q  <= '0;
      avg_q    <= '0;
      seeded_q <= 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cmef_pkg::CFG_MIN_LIMIT:   min_q   <= cfg_data_i;
          cmef_pkg::CFG_MAX_LIMIT:   max_q   <= cfg_data_i;
          cmef_pkg::CFG_WINDOW_SIZE: ws_q    <= cfg_data_i[cmef_pkg::WSIZE_W-1:0];
          cmef_pkg::CFG_EMA_ALPHA:   alpha_q <= cfg_data_i;
        endcase
      end
      if (cmd_i.load) begin
        win_q[ptr_eff] <= clamp_val;
        ptr_q          <= ptr_nxt;
        if (count_q < size) begin
          count_q <= count_q + NW'(1);
        end
      end
      if (cmd_i.upd) begin
        seeded_q <= 1'b1;
        if (!seeded_q) begin
          avg_q <= med_q;
        end else begin
          avg_q <= CW'(avg_sum);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
    if (cmd_i.load) begin
      clamp_q <= clamp_val;
    end
    if (cmd_i.prep) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        val_q[i] <= win_q[i];
        pad_q[i] <= (NW'(i) >= n_used);
      end
      round_q   <= '0;
      med_idx_q <= PW'(n_used >> 1);
      ready_q   <= (count_q >= size);
    end
    if (cmd_i.sort) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        val_q[i] <= val_n[i];
        pad_q[i] <= pad_n[i];
      end
      round_q <= round_q + NW'(1);
    end
    if (cmd_i.med) begin
      med_q <= val_q[med_idx_q];
    end
    if (cmd_i.diff) begin
      diff_q <= DW'(med_q) - DW'(avg_q);
    end
    if (cmd_i.mul) begin
      prod_q <= $signed({1'b0, alpha_eff}) * diff_q;
    end
    if (cmd_i.out_load) begin
      clamped_q   <= SAMPLE_BITS'(clamp_q);
      median_q    <= SAMPLE_BITS'(med_q);
      filtered_q  <= SAMPLE_BITS'(avg_q);
      ready_res_q <= ready_q;
    end
  end

  assign sts_o.sort_last = (round_q == NW'(MAX_WINDOW - 1));

  assign clamped_o   = clamped_q;
  assign median_o    = median_q;
  assign filtered_o  = filtered_q;
  assign ready_res_o = ready_res_q;

endmodule

[rtl/core/clamp_median_ema_filter.sv]
// Channel  Handshake                Payload
// -------  -----------------------  ---------------------------------------
// in       in_valid_i / in_stall_o  sample_i
// out      out_valid_o/ out_stall_i clamped_o, median_o, filtered_o, ready_res_o
// cfg      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One item at a time: a new sample is taken only once the last result has been loaded for output.
// The median comes from MAX_WINDOW odd-even transposition rounds over the window copy;
// clamp, median pick, difference, multiply and average update each have a step of their own.
// Reset is asynchronous and active low; the window clears to zero and the average reseeds.
// A stalled result sits in the output register while the next request is taken.
module clamp_median_ema_filter #(
  parameter int MAX_WINDOW  = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]          clamped_o,
  output logic signed [SAMPLE_BITS-1:0]          median_o,
  output logic signed [SAMPLE_BITS-1:0]          filtered_o,
  output logic                                   ready_res_o,
  input  logic                                   cfg_we_i,
  input  logic [cmef_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [cmef_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  cmef_pkg::cmd_t cmd;
  cmef_pkg::sts_t sts;

  cmef_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  cmef_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (sample_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .clamped_o   (clamped_o),
    .median_o    (median_o),
    .filtered_o  (filtered_o),
    .ready_res_o (ready_res_o)
  );

endmodule

[rtl/core/cmef_checker.sv]
`include "assert_macros.svh"

module cmef_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] clamped_o,
  input logic signed [SAMPLE_BITS-1:0] median_o,
  input logic signed [SAMPLE_BITS-1:0] filtered_o,
  input logic                          ready_res_o
);

  logic                   in_acc;
  logic                   out_hold;
  logic [3*SAMPLE_BITS:0] out_bus;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;
  assign out_bus  = {clamped_o, median_o, filtered_o, ready_res_o};

  // a stalled result keeps its value
  `CMEF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(out_bus))

  // a request keeps the block busy for the following cycle
  `CMEF_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_acc, in_stall_o)

  // no result appears right after a request
  `CMEF_ASSERT_NXT(a_no_instant_result, clk_i, rst_ni, in_acc, !$rose(out_valid_o))

  // posting a result frees the input side
  `CMEF_ASSERT_IMP(a_free_on_result, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

endmodule

bind clamp_median_ema_filter cmef_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cmef_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .clamped_o   (clamped_o),
  .median_o    (median_o),
  .filtered_o  (filtered_o),
  .ready_res_o (ready_res_o)
);
